// File: hdl/mqs_pkg.sv
// Shared types and constants for the multi-queue shared store.
package mqs_pkg;

  localparam int DEF_QUEUE_COUNT     = 4;
  localparam int DEF_SLOTS_PER_QUEUE = 8;
  localparam int JOB_QUEUE_DEPTH     = 2;
  localparam int DATA_W              = 32;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_IGNORE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    JOB_STATUS = 2'd0,
    JOB_WRITE  = 2'd1,
    JOB_READ   = 2'd2,
    JOB_LIST   = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    status_t   status;
  } job_ctl_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_LIST = 1'b1
  } back_state_t;

endpackage

// File: hdl/mqs_front.sv
// Front end: classifies each transaction, owns the queue counters and emits jobs.
module mqs_front import mqs_pkg::*; #(
  parameter int QUEUE_COUNT     = DEF_QUEUE_COUNT,
  parameter int SLOTS_PER_QUEUE = DEF_SLOTS_PER_QUEUE,
  localparam int AW = (QUEUE_COUNT * SLOTS_PER_QUEUE > 1) ?
                      $clog2(QUEUE_COUNT * SLOTS_PER_QUEUE) : 1,
  localparam int CW = $clog2(SLOTS_PER_QUEUE + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              full,
  input  logic [1:0]        action,
  input  logic [2:0]        queue_number,
  input  logic [DATA_W-1:0] data_value,
  output logic              push,
  output job_ctl_t          job_ctl,
  output logic [AW-1:0]     job_addr,
  output logic [CW-1:0]     job_count,
  output logic [DATA_W-1:0] job_data
);

  localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam logic [AW-1:0] SLICE = AW'(SLOTS_PER_QUEUE);
  localparam logic [CW-1:0] FULL_MARK = CW'(SLOTS_PER_QUEUE);

  logic [CW-1:0] inserted_count [QUEUE_COUNT];
  logic [CW-1:0] removed_count  [QUEUE_COUNT];

  logic          accept;
  logic          q_valid;
  logic [QW-1:0] qi;
  logic [CW-1:0] ins_cur;
  logic [CW-1:0] rem_cur;
  logic [AW-1:0] base;
  logic          do_insert;
  logic          do_remove;

  assign accept  = start && !full;
  assign q_valid = ({1'b0, queue_number} < 4'(QUEUE_COUNT));
  assign qi      = QW'(queue_number);
  assign ins_cur = q_valid ? inserted_count[qi] : '0;
  assign rem_cur = q_valid ? removed_count[qi] : '0;
  assign base    = AW'(AW'(qi) * SLICE);
  assign job_data = data_value;

  always_comb begin
    push           = 1'b0;
    job_ctl.kind   = JOB_STATUS;
    job_ctl.status = ST_OK;
    job_addr       = base;
    job_count      = CW'(ins_cur - rem_cur);
    do_insert      = 1'b0;
    do_remove      = 1'b0;
    if (accept && action_t'(action) != ACT_IGNORE) begin
      push = 1'b1;
      priority if (!q_valid) begin
        job_ctl.status = ST_INVALID;
      end else if (action_t'(action) == ACT_INSERT) begin
        if (ins_cur == FULL_MARK) begin
          job_ctl.status = ST_OVERFLOW;
        end else begin
          job_ctl.kind = JOB_WRITE;
          job_addr     = AW'(base + AW'(ins_cur));
          do_insert    = 1'b1;
        end
      end else if (rem_cur == ins_cur) begin
        job_ctl.status = ST_EMPTY;
      end else if (action_t'(action) == ACT_REMOVE) begin
        job_ctl.kind = JOB_READ;
        job_addr     = AW'(base + AW'(rem_cur));
        do_remove    = 1'b1;
      end else begin
        job_ctl.kind = JOB_LIST;
        job_addr     = AW'(base + AW'(rem_cur));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QUEUE_COUNT; i++) begin
        inserted_count[i] <= '0;
        removed_count[i]  <= '0;
      end
    end else begin
      if (do_insert) inserted_count[qi] <= CW'(ins_cur + CW'(1));
      if (do_remove) removed_count[qi]  <= CW'(rem_cur + CW'(1));
    end
  end

endmodule

// File: hdl/mqs_job_queue.sv
// Short job queue that decouples the front end from the back end.
module mqs_job_queue import mqs_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = JOB_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full     = (fill == NW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + PW'(1));
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + PW'(1));
      end
      fill <= NW'(fill + NW'(push && !full) - NW'(pop && !empty));
    end
  end

endmodule

// File: hdl/mqs_back.sv
// Back end: carries out jobs against the slot store and drives the results.
module mqs_back import mqs_pkg::*; #(
  parameter int QUEUE_COUNT     = DEF_QUEUE_COUNT,
  parameter int SLOTS_PER_QUEUE = DEF_SLOTS_PER_QUEUE,
  localparam int AW = (QUEUE_COUNT * SLOTS_PER_QUEUE > 1) ?
                      $clog2(QUEUE_COUNT * SLOTS_PER_QUEUE) : 1,
  localparam int CW = $clog2(SLOTS_PER_QUEUE + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     empty,
  input  job_ctl_t                 job_ctl,
  input  logic [AW-1:0]            job_addr,
  input  logic [CW-1:0]            job_count,
  input  logic [DATA_W-1:0]        job_data,
  output logic                     pop,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] value_out,
  output logic                     last_of_run
);

  localparam int STORE_DEPTH = QUEUE_COUNT * SLOTS_PER_QUEUE;

  logic [DATA_W-1:0] slot_store [STORE_DEPTH];
  logic [DATA_W-1:0] rdata;

  back_state_t   state, state_next;
  logic [AW-1:0] cur_addr, cur_addr_next;
  logic [CW-1:0] remaining, remaining_next;

  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic          issue_valid;
  status_t       issue_status;
  logic          issue_last;
  logic          issue_use_mem;
  logic          issue_zero;

  logic          s1_valid;
  status_t       s1_status;
  logic          s1_last;
  logic          s1_use_mem;
  logic          s1_zero;

  always_comb begin
    state_next     = state;
    cur_addr_next  = cur_addr;
    remaining_next = remaining;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = job_addr;
    issue_valid    = 1'b0;
    issue_status   = ST_OK;
    issue_last     = 1'b1;
    issue_use_mem  = 1'b0;
    issue_zero     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!empty) begin
          pop         = 1'b1;
          issue_valid = 1'b1;
          unique case (job_ctl.kind)
            JOB_STATUS: issue_status = job_ctl.status;
            JOB_WRITE: begin
              mem_we     = 1'b1;
              issue_zero = 1'b1;
            end
            JOB_READ: begin
              mem_re        = 1'b1;
              issue_use_mem = 1'b1;
            end
            JOB_LIST: begin
              mem_re        = 1'b1;
              issue_use_mem = 1'b1;
              if (job_count != CW'(1)) begin
                issue_last     = 1'b0;
                state_next     = BK_LIST;
                cur_addr_next  = AW'(job_addr + AW'(1));
                remaining_next = CW'(job_count - CW'(1));
              end
            end
            default: issue_status = job_ctl.status;
          endcase
        end
      end
      BK_LIST: begin
        mem_re         = 1'b1;
        mem_addr       = cur_addr;
        issue_valid    = 1'b1;
        issue_use_mem  = 1'b1;
        issue_last     = (remaining == CW'(1));
        cur_addr_next  = AW'(cur_addr + AW'(1));
        remaining_next = CW'(remaining - CW'(1));
        if (remaining == CW'(1)) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_addr  <= cur_addr_next;
    remaining <= remaining_next;
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_store[mem_addr] <= job_data;
    if (mem_re) rdata <= slot_store[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_status  <= issue_status;
    s1_last    <= issue_last;
    s1_use_mem <= issue_use_mem;
    s1_zero    <= issue_zero;
  end

  assign strobe      = s1_valid;
  assign status      = s1_status;
  assign last_of_run = s1_last;
  assign value_out   = s1_use_mem ? $signed(rdata) :
                       (s1_zero ? '0 : '1);

`ifndef SYNTHESIS
  // A list run streams its results in consecutive cycles.
  a_run_no_gap: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_last |=> s1_valid)
    else $error("list run broken by an idle cycle");

  // A failed transaction reports all ones and ends its run.
  a_fail_shape: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_status != ST_OK |-> s1_last && value_out == '1)
    else $error("failure result malformed");

  // No new job is taken while a list run is in progress.
  a_no_pop_in_list: assert property (@(posedge clk) disable iff (rst)
    state == BK_LIST |-> !pop)
    else $error("job popped during list run");
`endif

endmodule

// File: hdl/multi_queue_shared_store.sv
// Top level of the multi-queue shared store: front end, job queue and back end.
//
//   Channel   Signals                                   Transaction when
//   -------   ---------------------------------------   ----------------------
//   command   start, busy, action, queue_number,        start high, busy low
//             data_value
//   result    strobe, status, value_out, last_of_run    strobe high (no stall)
//
// Insert, remove and failed commands each give a single result; a list of n
// held entries gives n results, one read of the slot store per result.
// Commands with the unused action code are dropped by the front end and never
// reach the back end. With the back end idle, a command is written into the
// job queue at its transaction, then popped by the back end, whose result
// register drives the result ports. busy rises while the two-entry job queue is full,
// which happens when a list run holds the back end. Reset is synchronous and
// clears the queue counters, the job queue and the result strobe; the slot
// store itself is not cleared. The receiver cannot stall, so results are
// never held back once issued.
module multi_queue_shared_store import mqs_pkg::*; #(
  parameter int QUEUE_COUNT     = DEF_QUEUE_COUNT,
  parameter int SLOTS_PER_QUEUE = DEF_SLOTS_PER_QUEUE
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               action,
  input  logic [2:0]               queue_number,
  input  logic signed [DATA_W-1:0] data_value,
  output logic                     strobe,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] value_out,
  output logic                     last_of_run
);

  // Store address and entry count widths follow the queue geometry.
  localparam int AW = (QUEUE_COUNT * SLOTS_PER_QUEUE > 1) ?
                      $clog2(QUEUE_COUNT * SLOTS_PER_QUEUE) : 1;
  localparam int CW = $clog2(SLOTS_PER_QUEUE + 1);
  localparam int JW = $bits(job_ctl_t) + AW + CW + DATA_W;

  logic              push;
  logic              pop;
  logic              full;
  logic              empty;
  job_ctl_t          f_ctl, b_ctl;
  logic [AW-1:0]     f_addr, b_addr;
  logic [CW-1:0]     f_count, b_count;
  logic [DATA_W-1:0] f_data, b_data;
  logic [JW-1:0]     q_in, q_out;

  // A command is taken whenever the job queue has room.
  assign busy = full;

  mqs_front #(
    .QUEUE_COUNT     (QUEUE_COUNT),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .full         (full),
    .action       (action),
    .queue_number (queue_number),
    .data_value   (data_value),
    .push         (push),
    .job_ctl      (f_ctl),
    .job_addr     (f_addr),
    .job_count    (f_count),
    .job_data     (f_data)
  );

  assign q_in = {f_ctl, f_addr, f_count, f_data};

  mqs_job_queue #(
    .WIDTH (JW),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_job_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .pop_data  (q_out),
    .full      (full),
    .empty     (empty)
  );

  assign {b_ctl, b_addr, b_count, b_data} = q_out;

  mqs_back #(
    .QUEUE_COUNT     (QUEUE_COUNT),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .empty       (empty),
    .job_ctl     (b_ctl),
    .job_addr    (b_addr),
    .job_count   (b_count),
    .job_data    (b_data),
    .pop         (pop),
    .strobe      (strobe),
    .status      (status),
    .value_out   (value_out),
    .last_of_run (last_of_run)
  );

endmodule
